// File: src/rrsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared types and constants for the raster row six-bit packer.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    // Character codes on the printer link
    localparam logic [7:0] CHAR_ESC       = 8'h1B;
    localparam logic [7:0] CHAR_GFX       = 8'h67;  // 'g'
    localparam logic [7:0] CHAR_TERM      = 8'h20;
    localparam logic [7:0] CHAR_TERM_LAST = 8'h28;
    localparam logic [1:0] CHAR_OFFSET    = 2'b01;  // 0x40 over a six-bit field

    // Data characters in a full row
    localparam logic [6:0] FULL_ROW_CHARS = 7'd64;

    // Results caused by one byte, at most
    localparam int unsigned MAX_RESULTS = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_ROW_BYTES = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT = 2'd1;

    // Position of a byte within its three-byte group
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // Row tracking state
    typedef struct packed {
        logic [15:0] row_index;
        logic [7:0]  byte_in_row;
        t_phase      phase;
        logic [7:0]  held_byte;
        logic [6:0]  chars_in_row;
    } t_row_state;

    // Characters produced by one byte
    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][7:0]  chars;
        logic [3:0]       ends;
    } t_pack_result;

endpackage

// File: src/rrsp_char_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_char_gen
// Turns one bitmap byte and the row state into its list of link characters
// and the row state that follows.
// ----------------------------------------------------------------------------
module rrsp_char_gen #(
    parameter int MAX_ROW_BYTES = 48
) (
    input  rrsp_pkg::t_row_state   i_state,
    input  logic [7:0]             i_row_bytes,
    input  logic [15:0]            i_row_count,
    input  logic [7:0]             i_pixel_byte,
    output rrsp_pkg::t_pack_result o_result,
    output rrsp_pkg::t_row_state   o_state
);

    logic       last_row;
    logic       row_done;
    logic       header;
    logic       in_range;
    logic [1:0] data_n;
    logic [5:0] six0;
    logic [5:0] six1;
    logic [7:0] held_nxt;
    logic [6:0] chars_after;
    logic       full_mark;
    logic       term;
    logic [2:0] cnt;

    // Row and image boundaries
    assign last_row = ({1'b0, i_state.row_index} + 17'd1) >= {1'b0, i_row_count};
    assign row_done = ({1'b0, i_state.byte_in_row} + 9'd1) >= {1'b0, i_row_bytes};
    assign header   = (i_state.row_index == 16'd0) && (i_state.byte_in_row == 8'd0);
    assign in_range = i_state.byte_in_row < 8'(MAX_ROW_BYTES);

    // Split the byte into six-bit fields by its place in the group
    always_comb begin
        six0     = 6'd0;
        six1     = 6'd0;
        held_nxt = i_state.held_byte;
        data_n   = 2'd0;
        if (in_range) begin
            unique case (i_state.phase)
                rrsp_pkg::PH_FIRST: begin
                    six0     = i_pixel_byte[7:2];
                    held_nxt = {6'd0, i_pixel_byte[1:0]};
                    data_n   = 2'd1;
                end
                rrsp_pkg::PH_SECOND: begin
                    six0     = {i_state.held_byte[1:0], i_pixel_byte[7:4]};
                    held_nxt = {4'd0, i_pixel_byte[3:0]};
                    data_n   = 2'd1;
                end
                rrsp_pkg::PH_THIRD: begin
                    six0     = {i_state.held_byte[3:0], i_pixel_byte[7:6]};
                    six1     = i_pixel_byte[5:0];
                    held_nxt = 8'd0;
                    data_n   = 2'd2;
                end
                default: begin
                    data_n = 2'd0;
                end
            endcase
        end
    end

    // Full-row mark and terminator decision
    assign chars_after = i_state.chars_in_row + {5'd0, data_n};
    assign full_mark   = !last_row && (i_state.chars_in_row < rrsp_pkg::FULL_ROW_CHARS)
                         && (chars_after >= rrsp_pkg::FULL_ROW_CHARS);
    assign term        = row_done
                         && ((chars_after < rrsp_pkg::FULL_ROW_CHARS) || last_row);

    // Build the character list in link order
    always_comb begin
        o_result = '0;
        cnt      = 3'd0;
        if (header) begin
            o_result.chars[cnt[1:0]] = rrsp_pkg::CHAR_ESC;
            cnt                      = cnt + 3'd1;
            o_result.chars[cnt[1:0]] = rrsp_pkg::CHAR_GFX;
            cnt                      = cnt + 3'd1;
        end
        if (data_n != 2'd0) begin
            o_result.chars[cnt[1:0]] = {rrsp_pkg::CHAR_OFFSET, six0};
            o_result.ends[cnt[1:0]]  = full_mark && (data_n == 2'd1);
            cnt                      = cnt + 3'd1;
        end
        if (data_n == 2'd2) begin
            o_result.chars[cnt[1:0]] = {rrsp_pkg::CHAR_OFFSET, six1};
            o_result.ends[cnt[1:0]]  = full_mark;
            cnt                      = cnt + 3'd1;
        end
        if (term) begin
            o_result.chars[cnt[1:0]] = last_row ? rrsp_pkg::CHAR_TERM_LAST
                                                : rrsp_pkg::CHAR_TERM;
            o_result.ends[cnt[1:0]]  = 1'b1;
            cnt                      = cnt + 3'd1;
        end
        o_result.count = cnt;
    end

    // Advance the row state
    always_comb begin
        o_state = i_state;
        if (row_done) begin
            o_state.byte_in_row  = 8'd0;
            o_state.phase        = rrsp_pkg::PH_FIRST;
            o_state.chars_in_row = 7'd0;
            o_state.held_byte    = 8'd0;
            o_state.row_index    = last_row ? 16'd0 : i_state.row_index + 16'd1;
        end else begin
            o_state.byte_in_row  = i_state.byte_in_row + 8'd1;
            o_state.chars_in_row = chars_after;
            o_state.held_byte    = held_nxt;
            unique case (i_state.phase)
                rrsp_pkg::PH_FIRST:  o_state.phase = rrsp_pkg::PH_SECOND;
                rrsp_pkg::PH_SECOND: o_state.phase = rrsp_pkg::PH_THIRD;
                default:             o_state.phase = rrsp_pkg::PH_FIRST;
            endcase
        end
    end

endmodule

// File: src/raster_row_six_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_row_six_bit_packer
// Packs bitmap bytes into 0x40-offset six-bit printer characters, with the
// graphics escape at image start and a terminator ending short or last rows.
//
//   channel   direction  handshake                    payload
//   pixel     in         i_valid / o_ready            i_pixel_byte
//   result    out        o_valid / i_ready            o_out_char, o_row_end,
//                                                     o_last_of_run
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A byte is taken with its zero to four characters into the result queue,
// which they leave one per cycle unless the output stalls. The next byte
// is taken in the cycle that its predecessor's last character transfers.
// Output stalls hold the queue and block input while any character waits
// untaken, the final one included. Reset is synchronous, restores the
// register defaults and starts a new image.
// ----------------------------------------------------------------------------
module raster_row_six_bit_packer #(
    parameter int MAX_ROW_BYTES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_row_end,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]             r_row_bytes;
    logic [15:0]            r_row_count;
    rrsp_pkg::t_row_state   r_state;
    rrsp_pkg::t_row_state   n_state;
    rrsp_pkg::t_pack_result gen_result;
    logic [3:0][7:0]        r_chars;
    logic [3:0]             r_ends;
    logic [2:0]             r_cnt;
    logic                   in_xfer;
    logic                   out_xfer;

    // Character generation for the byte on the port
    rrsp_char_gen #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_char_gen (
        .i_state     (r_state),
        .i_row_bytes (r_row_bytes),
        .i_row_count (r_row_count),
        .i_pixel_byte(i_pixel_byte),
        .o_result    (gen_result),
        .o_state     (n_state)
    );

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_ready);
    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = o_valid && i_ready;

    // Result queue head
    assign o_valid       = r_cnt != 3'd0;
    assign o_out_char    = r_chars[0];
    assign o_row_end     = r_ends[0];
    assign o_last_of_run = r_cnt == 3'd1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= 8'd48;
            r_row_count <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == rrsp_pkg::REG_ROW_BYTES) begin
                r_row_bytes <= i_cfg_data[7:0];
            end else if (i_cfg_index == rrsp_pkg::REG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end
        end
    end

    // Row state: advance on each byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Result queue: load a byte's characters, or drop the head on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (in_xfer) begin
            r_cnt <= gen_result.count;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_chars <= gen_result.chars;
            r_ends  <= gen_result.ends;
        end else if (out_xfer) begin
            r_chars <= {8'd0, r_chars[3:1]};
            r_ends  <= {1'b0, r_ends[3:1]};
        end
    end

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(rrsp_pkg::MAX_RESULTS))
        else $error("result queue holds more than one byte's characters");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 3'd1) |-> !o_ready)
        else $error("byte taken while earlier characters wait");

    a_row_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row_end) |-> o_last_of_run)
        else $error("row end marked before the byte's final character");

    a_chars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.chars_in_row <= rrsp_pkg::FULL_ROW_CHARS)
        else $error("row character count beyond a full row");

endmodule

// File: tb/sv/rrsp_char_stream_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_char_stream_check
// Watches the pixel, configuration and character channels of the raster row
// six-bit packer. Keeps its own copy of the row state and registers, works
// out the printer characters due for every pixel byte transfer and compares
// each character transfer, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module rrsp_char_stream_check #(
    parameter int MAX_ROW_BYTES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_valid,
    input  logic        i_pix_ready,
    input  logic [7:0]  i_pixel_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_char,
    input  logic        i_row_end,
    input  logic        i_last_of_run,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int unsigned o_mismatches,
    output int unsigned o_waiting,
    output int unsigned o_bytes_seen,
    output int unsigned o_chars_seen,
    output int unsigned o_rows_seen
);

    localparam int unsigned REPORT_LIMIT = 10;

    // One character on the printer link with its markers
    typedef struct packed {
        logic [7:0] code;
        logic       row_end;
        logic       last;
    } t_link_char;

    // Register copies
    logic [7:0]  row_len;
    logic [15:0] rows_total;

    // Row tracking copy
    logic [15:0] row_idx;
    logic [7:0]  byte_pos;
    logic [3:0]  carry_bits;
    logic [6:0]  data_chars;

    t_link_char due_chars[$];

    // Work out the characters one pixel byte causes and advance the row state
    task automatic pack_byte_chars(input logic [7:0] px);
        logic [7:0]         codes [0:3];
        logic               ends  [0:3];
        int                 n;
        bit                 last_row;
        bit                 row_done;
        logic [6:0]         sent_before;
        rrsp_pkg::t_phase   slot;
        t_link_char         item;
        n           = 0;
        last_row    = ({1'b0, row_idx} + 17'd1) >= {1'b0, rows_total};
        row_done    = ({1'b0, byte_pos} + 9'd1) >= {1'b0, row_len};
        sent_before = data_chars;

        // graphics escape at the start of an image
        if (row_idx == 16'd0 && byte_pos == 8'd0) begin
            codes[0] = rrsp_pkg::CHAR_ESC;
            ends[0]  = 1'b0;
            codes[1] = rrsp_pkg::CHAR_GFX;
            ends[1]  = 1'b0;
            n        = 2;
        end

        // split the byte over the six-bit fields of its group; drop overlong bytes
        if (byte_pos < MAX_ROW_BYTES) begin
            slot = rrsp_pkg::t_phase'(2'(byte_pos % 8'd3));
            case (slot)
                rrsp_pkg::PH_FIRST: begin
                    codes[n]   = {rrsp_pkg::CHAR_OFFSET, px[7:2]};
                    ends[n]    = 1'b0;
                    n          = n + 1;
                    data_chars = data_chars + 7'd1;
                    carry_bits = {2'b00, px[1:0]};
                end
                rrsp_pkg::PH_SECOND: begin
                    codes[n]   = {rrsp_pkg::CHAR_OFFSET, carry_bits[1:0], px[7:4]};
                    ends[n]    = 1'b0;
                    n          = n + 1;
                    data_chars = data_chars + 7'd1;
                    carry_bits = px[3:0];
                end
                default: begin
                    codes[n]     = {rrsp_pkg::CHAR_OFFSET, carry_bits[3:0], px[7:6]};
                    ends[n]      = 1'b0;
                    codes[n + 1] = {rrsp_pkg::CHAR_OFFSET, px[5:0]};
                    ends[n + 1]  = 1'b0;
                    n            = n + 2;
                    data_chars   = data_chars + 7'd2;
                    carry_bits   = 4'd0;
                end
            endcase
        end

        // a full row that is not the last ends on its 64th character
        if (!last_row && sent_before < rrsp_pkg::FULL_ROW_CHARS
            && data_chars >= rrsp_pkg::FULL_ROW_CHARS && n > 0)
            ends[n - 1] = 1'b1;

        if (row_done && (data_chars < rrsp_pkg::FULL_ROW_CHARS || last_row)) begin
            codes[n] = last_row ? rrsp_pkg::CHAR_TERM_LAST : rrsp_pkg::CHAR_TERM;
            ends[n]  = 1'b1;
            n        = n + 1;
        end

        // advance to the next byte, row or image
        if (row_done) begin
            byte_pos   = 8'd0;
            data_chars = 7'd0;
            carry_bits = 4'd0;
            row_idx    = last_row ? 16'd0 : row_idx + 16'd1;
        end else begin
            byte_pos = byte_pos + 8'd1;
        end

        for (int k = 0; k < n; k++) begin
            item.code    = codes[k];
            item.row_end = ends[k];
            item.last    = (k == n - 1);
            due_chars.push_back(item);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_link_char got;
        t_link_char want;
        if (!i_rst_n) begin
            row_len      = 8'd48;
            rows_total   = 16'd1;
            row_idx      = 16'd0;
            byte_pos     = 8'd0;
            carry_bits   = 4'd0;
            data_chars   = 7'd0;
            due_chars.delete();
            o_mismatches = 0;
            o_bytes_seen = 0;
            o_chars_seen = 0;
            o_rows_seen  = 0;
        end else begin
            // register writes; unmapped indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rrsp_pkg::REG_ROW_BYTES: row_len    = i_cfg_data[7:0];
                    rrsp_pkg::REG_ROW_COUNT: rows_total = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_pix_valid && i_pix_ready) begin
                pack_byte_chars(i_pixel_byte);
                o_bytes_seen++;
            end

            // compare each character transfer with the oldest one due
            if (i_out_valid && i_out_ready) begin
                got = '{code: i_out_char, row_end: i_row_end, last: i_last_of_run};
                o_chars_seen++;
                if (i_row_end)
                    o_rows_seen++;
                if (due_chars.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT)
                        $display("[%0t] char %02h row_end %b last %b arrived with none due",
                                 $realtime, got.code, got.row_end, got.last);
                    o_mismatches++;
                end else begin
                    want = due_chars.pop_front();
                    if (want != got) begin
                        if (o_mismatches < REPORT_LIMIT)
                            $display("[%0t] char mismatch: want %02h/%b/%b got %02h/%b/%b",
                                     $realtime, want.code, want.row_end, want.last,
                                     got.code, got.row_end, got.last);
                        o_mismatches++;
                    end
                end
            end
        end
        o_waiting = due_chars.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the raster row six-bit packer. A short directed run walks
// the register extremes, short groups and image restarts; then images of
// random bytes follow, full and overlong rows among them and some broken
// off mid-row, with random pixel-side gaps and character-side stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          MAX_ROW_BYTES = 48;
    localparam int          CLK_HALF      = 2;
    localparam int unsigned RANDOM_BYTES  = 260;
    localparam int unsigned HOLD_CYCLES   = 120;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 8;
    // hard stop: about 300 bytes, each up to four characters behind sink
    // stalls, plus sender gaps and drains, must finish before it
    localparam int          TIMEOUT_NS    = 1_600_000;

    // Register indexes with no register behind them
    localparam logic [1:0] REG_SPARE_LOW  = 2'd2;
    localparam logic [1:0] REG_SPARE_HIGH = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_pixel_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_char;
    logic        o_row_end;
    logic        o_last_of_run;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int unsigned mismatches;
    int unsigned waiting;
    int unsigned bytes_seen;
    int unsigned chars_seen;
    int unsigned rows_seen;
    int unsigned reg_writes;
    int unsigned hold_asks;
    int unsigned hold_done;

    raster_row_six_bit_packer #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_byte  (i_pixel_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_row_end     (o_row_end),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rrsp_char_stream_check #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_char_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_valid),
        .i_pix_ready   (o_ready),
        .i_pixel_byte  (i_pixel_byte),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_char    (o_out_char),
        .i_row_end     (o_row_end),
        .i_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_waiting     (waiting),
        .o_bytes_seen  (bytes_seen),
        .o_chars_seen  (chars_seen),
        .o_rows_seen   (rows_seen)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Hard stop
    initial begin
        #TIMEOUT_NS;
        $display("raster_row_six_bit_packer regression: fail");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Character side: random stalls, plus a long hold-off on request
    initial begin : char_sink
        int unsigned run;
        int unsigned gap;
        i_ready   = 1'b0;
        hold_done = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_asks != hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                i_ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
                // cut the run short as soon as a hold-off is asked for
                while (run != 0 && hold_asks == hold_done) begin
                    @(posedge i_clk);
                    run--;
                end
                gap = pick_gap();
                if (gap != 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Offer one pixel byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] value, input bit eager);
        int unsigned gap;
        gap = eager ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pixel_byte <= value;
        // sample ready away from the edge, then take the accepting edge
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random(input int unsigned count, input bit eager);
        for (int unsigned k = 0; k < count; k++)
            send_byte(8'($urandom_range(0, 255)), eager);
    endtask

    // Drop valid, wait until no character is due or the drain limit runs out
    task automatic drain_chars();
        int unsigned waited;
        waited  = 0;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (waiting != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned phase_no;
        int unsigned phase_bytes;
        int unsigned rows_eff;
        int unsigned kind;
        logic [7:0]  len_cfg;
        logic [15:0] rows_cfg;
        bit          eager;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_pixel_byte = 8'd0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = rrsp_pkg::REG_ROW_BYTES;
        i_cfg_data   = 16'd0;
        reg_writes   = 0;
        hold_asks    = 0;
        random_sent  = 0;
        phase_no     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: image start and all three group positions
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain_chars();
        // lower the row length mid-row: the next byte closes the row at once
        write_reg(rrsp_pkg::REG_ROW_BYTES, {8'($urandom_range(0, 255)), 8'd2});
        send_byte(8'hC3, 1'b0);
        drain_chars();

        // Zero row length and zero row count: every byte is a whole image
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'hFF00);
        write_reg(rrsp_pkg::REG_ROW_COUNT, 16'h0000);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        drain_chars();

        // Unmapped indexes, then two-byte rows ending on a short group
        write_reg(REG_SPARE_LOW, 16'hFFFF);
        write_reg(REG_SPARE_HIGH, 16'h5AA5);
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'h0002);
        write_reg(rrsp_pkg::REG_ROW_COUNT, 16'h0002);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain_chars();

        // Widest row and highest row count, cut short by lowering both
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'h00FF);
        write_reg(rrsp_pkg::REG_ROW_COUNT, 16'hFFFF);
        send_random(4, 1'b0);
        drain_chars();
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'h0001);
        send_byte(8'hF0, 1'b0);
        drain_chars();
        write_reg(rrsp_pkg::REG_ROW_COUNT, 16'h0001);
        send_byte(8'h0F, 1'b0);
        drain_chars();

        // Three-row image: a full row, an overlong row, then a full last row.
        // The character side holds off while the first row streams in.
        write_reg(rrsp_pkg::REG_ROW_COUNT, 16'd3);
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'd48);
        hold_asks++;
        send_random(48, 1'b1);
        drain_chars();
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'd50);
        send_random(50, 1'b0);
        drain_chars();
        write_reg(rrsp_pkg::REG_ROW_BYTES, 16'd48);
        send_random(48, 1'b0);
        drain_chars();
        random_sent = 146;

        // Random images, a few of them broken off mid-row
        while (random_sent < RANDOM_BYTES) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                len_cfg  = 8'($urandom_range(1, 12));
                rows_cfg = 16'($urandom_range(1, 4));
            end else if (kind == 5) begin
                len_cfg  = 8'd0;
                rows_cfg = 16'($urandom_range(0, 3));
            end else if (kind == 6) begin
                len_cfg  = 8'($urandom_range(13, 47));
                rows_cfg = 16'($urandom_range(1, 2));
            end else if (kind == 7) begin
                len_cfg  = 8'($urandom_range(1, 6));
                rows_cfg = 16'($urandom_range(0, 65535));
            end else if (kind == 8) begin
                len_cfg  = 8'($urandom_range(1, 9));
                rows_cfg = 16'd1;
            end else begin
                len_cfg  = 8'($urandom_range(2, 8));
                rows_cfg = 16'($urandom_range(2, 5));
            end

            if ($urandom_range(0, 1) == 0) begin
                write_reg(rrsp_pkg::REG_ROW_BYTES, {8'($urandom_range(0, 255)), len_cfg});
                write_reg(rrsp_pkg::REG_ROW_COUNT, rows_cfg);
            end else begin
                write_reg(rrsp_pkg::REG_ROW_COUNT, rows_cfg);
                write_reg(rrsp_pkg::REG_ROW_BYTES, {8'($urandom_range(0, 255)), len_cfg});
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                          16'($urandom_range(0, 65535)));

            rows_eff    = (rows_cfg == 16'd0 || rows_cfg > 16'd4) ? $urandom_range(1, 3)
                                                                   : rows_cfg;
            phase_bytes = ((len_cfg == 8'd0) ? 1 : len_cfg) * rows_eff;
            if ($urandom_range(0, 4) == 0)
                phase_bytes = $urandom_range(1, phase_bytes);
            // keep the total close to the planned byte count
            if (phase_bytes > RANDOM_BYTES - random_sent)
                phase_bytes = RANDOM_BYTES - random_sent;

            eager = ($urandom_range(0, 3) == 0);
            if (phase_no == 2) begin
                hold_asks++;
                eager = 1'b1;
            end
            send_random(phase_bytes, eager);
            drain_chars();
            random_sent += phase_bytes;
            phase_no++;
        end

        drain_chars();
        @(negedge i_clk);
        if (waiting != 0)
            $display("%0d characters still due at the end", waiting);
        $display("covered %0d pixel bytes and %0d register writes; %0d characters checked",
                 bytes_seen, reg_writes, chars_seen);
        $display("%0d row ends seen over full, overlong, short-group and one-byte rows",
                 rows_seen);
        if (mismatches == 0 && waiting == 0) begin
            $display("raster_row_six_bit_packer regression: pass");
        end else begin
            $display("raster_row_six_bit_packer regression: fail");
        end
        $finish;
    end

endmodule
